@@ hw/rtl/hpt_pkg.sv @@
// Shared types and constants for the homogeneous point transform.
// Used by hpt_cfg_regs, hpt_dot_row and homogeneous_point_transform.
package hpt_pkg;

	localparam int XW      = 32;              // Q16.16 component width
	localparam int REG_W   = 64;              // configuration register width
	localparam int IDX_W   = 4;               // index width, covers writes past the list
	localparam int NUM_REGS = 8;
	localparam int FRAC_W  = 16;
	localparam int PROD_W  = 2 * XW;          // full product
	localparam int PAIR_W  = PROD_W + 1;      // sum of two products
	localparam int SUM_W   = PROD_W + 2;      // sum of four products

	typedef enum logic [2:0] {
		REG_I_XY = 3'd0,
		REG_I_ZW = 3'd1,
		REG_J_XY = 3'd2,
		REG_J_ZW = 3'd3,
		REG_K_XY = 3'd4,
		REG_K_ZW = 3'd5,
		REG_T_XY = 3'd6,
		REG_T_ZW = 3'd7
	} cfg_reg_t;

	// Reset matrix is the identity.
	localparam logic [REG_W-1:0] ONE_LO = 64'h0000_0000_0001_0000;
	localparam logic [REG_W-1:0] ONE_HI = 64'h0001_0000_0000_0000;

	localparam logic [XW-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [XW-1:0] SAT_MIN = 32'h8000_0000;

	typedef logic [NUM_REGS-1:0][REG_W-1:0] matrix_t;
	typedef logic [3:0][XW-1:0] vec4_t;

	typedef struct packed {
		logic          clip;
		logic [XW-1:0] val;
	} row_res_t;

	// Coefficients of one output row, one per column (I, J, K, T).
	function automatic vec4_t row_coefs(matrix_t m, logic [1:0] row);
		vec4_t            v;
		logic [REG_W-1:0] r;
		for (int c = 0; c < 4; c++) begin
			r = m[{c[1:0], row[1]}];
			v[c] = row[0] ? r[REG_W-1:XW] : r[XW-1:0];
		end
		return v;
	endfunction

endpackage

@@ hw/rtl/homogeneous_point_transform.sv @@
// Homogeneous point transform: 4x4 Q16.16 matrix times (x, y, z, w).
// Depends on hpt_pkg, hpt_cfg_regs and hpt_dot_row.
//
// Usage:
//   Input: drive in_x..in_w and raise start; the point transfers at each edge
//   with start high and busy low. busy stays low, so one point per clock.
//   Output: done is high for one cycle with out_x..out_w and clipped; the
//   result transfers at the edge that ends that cycle. There is no back
//   pressure, the receiver must take every result.
//   Config: cfg_valid/cfg_ready with cfg_index and cfg_data write one of the
//   eight column registers; cfg_ready is always high and indexes 8..15 are
//   dropped. Write only while no point is in flight.
// Pipeline: multiply, pair add, final add and shift/saturate registers lie
//   between the start transfer and done. Throughput: 1 point per cycle, set
//   by the 16 parallel 32x32 multipliers of the first stage.
// Reset: arst_n clears the pipeline valid bits and loads the identity matrix.
//   Points in flight at reset are dropped.
module homogeneous_point_transform (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [hpt_pkg::XW-1:0]  in_x,
	input  logic signed [hpt_pkg::XW-1:0]  in_y,
	input  logic signed [hpt_pkg::XW-1:0]  in_z,
	input  logic signed [hpt_pkg::XW-1:0]  in_w,
	output logic                           done,
	output logic signed [hpt_pkg::XW-1:0]  out_x,
	output logic signed [hpt_pkg::XW-1:0]  out_y,
	output logic signed [hpt_pkg::XW-1:0]  out_z,
	output logic signed [hpt_pkg::XW-1:0]  out_w,
	output logic                           clipped,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hpt_pkg::IDX_W-1:0]      cfg_index,
	input  logic [hpt_pkg::REG_W-1:0]      cfg_data
);

	hpt_pkg::matrix_t  matrix;
	hpt_pkg::vec4_t    vec;
	hpt_pkg::row_res_t row_res [4];

	logic accept;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	hpt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.matrix   (matrix)
	);

	assign vec = {in_w, in_z, in_y, in_x};

	for (genvar r = 0; r < 4; r++) begin : g_row
		hpt_dot_row u_row (
			.clk  (clk),
			.coef (hpt_pkg::row_coefs(matrix, r[1:0])),
			.vec  (vec),
			.res  (row_res[r])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign done    = valid_s4;
	assign out_x   = row_res[0].val;
	assign out_y   = row_res[1].val;
	assign out_z   = row_res[2].val;
	assign out_w   = row_res[3].val;
	assign clipped = row_res[0].clip | row_res[1].clip | row_res[2].clip | row_res[3].clip;

	a_done_follows_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("result without a matching input transfer");

	a_transfer_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 (done || !arst_n))
		else $error("input transfer lost in the pipeline");

	a_clip_only_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clipped) |->
			((out_x == hpt_pkg::SAT_MAX) || (out_x == hpt_pkg::SAT_MIN) ||
			 (out_y == hpt_pkg::SAT_MAX) || (out_y == hpt_pkg::SAT_MIN) ||
			 (out_z == hpt_pkg::SAT_MAX) || (out_z == hpt_pkg::SAT_MIN) ||
			 (out_w == hpt_pkg::SAT_MAX) || (out_w == hpt_pkg::SAT_MIN)))
		else $error("clipped set with no saturated component");

endmodule

@@ hw/rtl/hpt_cfg_regs.sv @@
// Transform matrix register file: eight 64-bit column-pair registers.
// Depends on hpt_pkg.
module hpt_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [hpt_pkg::IDX_W-1:0]      wr_index,
	input  logic [hpt_pkg::REG_W-1:0]      wr_data,
	output hpt_pkg::matrix_t               matrix
);

	hpt_pkg::matrix_t regs_q;
	logic             in_range;

	assign in_range = (wr_index < hpt_pkg::IDX_W'(hpt_pkg::NUM_REGS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[hpt_pkg::REG_I_XY] <= hpt_pkg::ONE_LO;
			regs_q[hpt_pkg::REG_I_ZW] <= '0;
			regs_q[hpt_pkg::REG_J_XY] <= hpt_pkg::ONE_HI;
			regs_q[hpt_pkg::REG_J_ZW] <= '0;
			regs_q[hpt_pkg::REG_K_XY] <= '0;
			regs_q[hpt_pkg::REG_K_ZW] <= hpt_pkg::ONE_LO;
			regs_q[hpt_pkg::REG_T_XY] <= '0;
			regs_q[hpt_pkg::REG_T_ZW] <= hpt_pkg::ONE_HI;
		end else if (wr_en && in_range) begin
			regs_q[wr_index[2:0]] <= wr_data;
		end
	end

	assign matrix = regs_q;

	a_wr_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && in_range) |=> (regs_q[$past(wr_index[2:0])] == $past(wr_data)))
		else $error("config write did not land");

	a_wr_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !in_range) |=> $stable(regs_q))
		else $error("out-of-range config write changed the matrix");

endmodule

@@ hw/rtl/hpt_dot_row.sv @@
// One output row: four signed products, two-level adder tree, floor shift and saturate.
// Four register stages; payload only, valid tracking lives in the top level. Depends on hpt_pkg.
module hpt_dot_row (
	input  logic              clk,
	input  hpt_pkg::vec4_t    coef,
	input  hpt_pkg::vec4_t    vec,
	output hpt_pkg::row_res_t res
);

	localparam int SUM_W = hpt_pkg::SUM_W;
	localparam int TOP_W = SUM_W - hpt_pkg::FRAC_W - hpt_pkg::XW + 1; // bits that must agree

	logic signed [hpt_pkg::PROD_W-1:0] prod_s1 [4];
	logic signed [hpt_pkg::PAIR_W-1:0] pair_s2 [2];
	logic signed [SUM_W-1:0]           sum_s3;
	hpt_pkg::row_res_t                 res_s4;

	logic [TOP_W-1:0] top_bits;
	logic             ovf;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			prod_s1[i] <= $signed(coef[i]) * $signed(vec[i]);
		end
		pair_s2[0] <= hpt_pkg::PAIR_W'(prod_s1[0]) + hpt_pkg::PAIR_W'(prod_s1[1]);
		pair_s2[1] <= hpt_pkg::PAIR_W'(prod_s1[2]) + hpt_pkg::PAIR_W'(prod_s1[3]);
		sum_s3     <= SUM_W'(pair_s2[0]) + SUM_W'(pair_s2[1]);
	end

	// Arithmetic shift by 16 is just dropping the fraction bits; overflow when the
	// bits above the kept 32 are not a pure sign extension.
	assign top_bits = sum_s3[SUM_W-1:SUM_W-TOP_W];
	assign ovf      = !((&top_bits) || !(|top_bits));

	always_ff @(posedge clk) begin
		res_s4.clip <= ovf;
		if (ovf) begin
			res_s4.val <= sum_s3[SUM_W-1] ? hpt_pkg::SAT_MIN : hpt_pkg::SAT_MAX;
		end else begin
			res_s4.val <= sum_s3[hpt_pkg::FRAC_W+hpt_pkg::XW-1:hpt_pkg::FRAC_W];
		end
	end

	assign res = res_s4;

endmodule

@@ bench/hpt_point_checker.sv @@
// Scoreboard for homogeneous_point_transform: keeps a copy of the column
// registers, predicts each transformed point and compares it on done.
// Depends on hpt_pkg.
module hpt_point_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [hpt_pkg::XW-1:0]    in_x,
	input  logic [hpt_pkg::XW-1:0]    in_y,
	input  logic [hpt_pkg::XW-1:0]    in_z,
	input  logic [hpt_pkg::XW-1:0]    in_w,
	input  logic                      done,
	input  logic [hpt_pkg::XW-1:0]    out_x,
	input  logic [hpt_pkg::XW-1:0]    out_y,
	input  logic [hpt_pkg::XW-1:0]    out_z,
	input  logic [hpt_pkg::XW-1:0]    out_w,
	input  logic                      clipped,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [hpt_pkg::IDX_W-1:0] cfg_index,
	input  logic [hpt_pkg::REG_W-1:0] cfg_data,
	output int                        mismatches,
	output int                        pending
);
	import hpt_pkg::*;

	localparam int MAX_PRINTED = 40;
	localparam logic signed [SUM_W-1:0] SUM_MAX = {{(SUM_W-XW){1'b0}}, SAT_MAX};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {{(SUM_W-XW){1'b1}}, SAT_MIN};

	typedef struct packed {
		logic [XW-1:0] x;
		logic [XW-1:0] y;
		logic [XW-1:0] z;
		logic [XW-1:0] w;
		logic          clip;
	} point_t;

	matrix_t shadow_matrix;
	point_t  expected_points[$];
	int      mismatch_total = 0;
	int      result_index = 0;

	assign mismatches = mismatch_total;

	// Exact four-term dot product, floored by the Q16.16 shift, then clamped.
	function automatic row_res_t row_dot(matrix_t m, int row, vec4_t v);
		row_res_t                res;
		logic [REG_W-1:0]        word;
		logic signed [XW-1:0]    coef;
		logic signed [SUM_W-1:0] acc;
		logic signed [SUM_W-1:0] a;
		logic signed [SUM_W-1:0] b;
		logic signed [SUM_W-1:0] floored;
		int                      c;
		acc = '0;
		for (c = 0; c < 4; c++) begin
			word = m[c * 2 + row / 2];
			coef = (row % 2 == 1) ? word[REG_W-1:XW] : word[XW-1:0];
			a = coef;
			b = $signed(v[c]);
			acc = acc + a * b;
		end
		floored = acc >>> FRAC_W;
		res.clip = 1'b1;
		if (floored > SUM_MAX) begin
			res.val = SAT_MAX;
		end else if (floored < SUM_MIN) begin
			res.val = SAT_MIN;
		end else begin
			res.clip = 1'b0;
			res.val = floored[XW-1:0];
		end
		return res;
	endfunction

	function automatic point_t transform_point(matrix_t m, logic [XW-1:0] px,
			logic [XW-1:0] py, logic [XW-1:0] pz, logic [XW-1:0] pw);
		vec4_t    v;
		row_res_t rx;
		row_res_t ry;
		row_res_t rz;
		row_res_t rw;
		point_t   p;
		v = {pw, pz, py, px};
		rx = row_dot(m, 0, v);
		ry = row_dot(m, 1, v);
		rz = row_dot(m, 2, v);
		rw = row_dot(m, 3, v);
		p.x = rx.val;
		p.y = ry.val;
		p.z = rz.val;
		p.w = rw.val;
		p.clip = rx.clip | ry.clip | rz.clip | rw.clip;
		return p;
	endfunction

	task automatic report_mismatch(string what, logic [XW-1:0] got, logic [XW-1:0] want);
		mismatch_total++;
		if (mismatch_total <= MAX_PRINTED)
			$display("%0t: result %0d %s: got %h, want %h", $time, result_index, what, got, want);
	endtask

	task automatic compare_field(string what, logic [XW-1:0] got, logic [XW-1:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		point_t want;
		if (!arst_n) begin
			shadow_matrix = '0;
			shadow_matrix[REG_I_XY] = ONE_LO;
			shadow_matrix[REG_J_XY] = ONE_HI;
			shadow_matrix[REG_K_ZW] = ONE_LO;
			shadow_matrix[REG_T_ZW] = ONE_HI;
			expected_points.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_points.size() == 0) begin
					report_mismatch("result with no point in flight", '0, '0);
				end else begin
					want = expected_points.pop_front();
					compare_field("out_x", out_x, want.x);
					compare_field("out_y", out_y, want.y);
					compare_field("out_z", out_z, want.z);
					compare_field("out_w", out_w, want.w);
					compare_field("clipped", XW'(clipped), XW'(want.clip));
				end
				result_index++;
			end
			if (start && !busy)
				expected_points.push_back(transform_point(shadow_matrix, in_x, in_y, in_z, in_w));
			if (cfg_valid && cfg_ready && cfg_index < IDX_W'(NUM_REGS))
				shadow_matrix[cfg_index[2:0]] = cfg_data;
			pending <= expected_points.size();
		end
	end

endmodule

@@ bench/tb_homogeneous_point_transform.sv @@
// Testbench top for homogeneous_point_transform: drives points and column
// register writes; prediction and comparison live in hpt_point_checker.
// Depends on hpt_pkg, the RTL and hpt_point_checker.
module tb_homogeneous_point_transform;
	import hpt_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_POINTS = 258;
	localparam int NUM_PHASES   = 6;

	localparam logic [IDX_W-1:0] FIRST_SPARE_IDX = IDX_W'(NUM_REGS);
	localparam logic [IDX_W-1:0] LAST_SPARE_IDX  = '1;

	localparam logic [XW-1:0] Q_ONE     = 32'h0001_0000;
	localparam logic [XW-1:0] Q_NEG_ONE = 32'hFFFF_0000;
	localparam logic [XW-1:0] LSB_ONE   = 32'h0000_0001;
	localparam logic [XW-1:0] LSB_NEG   = 32'hFFFF_FFFF;
	localparam logic [XW-1:0] FRAC_ALL  = 32'h0000_FFFF;

	typedef enum logic [2:0] {
		MAT_IDENTITY,
		MAT_SMALL,
		MAT_EXTREME,
		MAT_MIX,
		MAT_FULL
	} mat_kind_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic signed [XW-1:0]  in_x = '0;
	logic signed [XW-1:0]  in_y = '0;
	logic signed [XW-1:0]  in_z = '0;
	logic signed [XW-1:0]  in_w = '0;
	logic                  done;
	logic signed [XW-1:0]  out_x;
	logic signed [XW-1:0]  out_y;
	logic signed [XW-1:0]  out_z;
	logic signed [XW-1:0]  out_w;
	logic                  clipped;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [REG_W-1:0]      cfg_data = '0;

	int mismatches;
	int pending;
	int idle_pct = 0;
	int cycle_count = 0;

	homogeneous_point_transform DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.in_x      (in_x),
		.in_y      (in_y),
		.in_z      (in_z),
		.in_w      (in_w),
		.done      (done),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_w     (out_w),
		.clipped   (clipped),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	hpt_point_checker u_point_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.in_x       (in_x),
		.in_y       (in_y),
		.in_z       (in_z),
		.in_w       (in_w),
		.done       (done),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.out_w      (out_w),
		.clipped    (clipped),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [XW-1:0] pick_coord();
		case ($urandom_range(9))
			0: return SAT_MAX;
			1: return SAT_MIN;
			2: return '0;
			3: return Q_ONE;
			4: return Q_NEG_ONE;
			5, 6: return $urandom_range(2097152) - 32'd1048576;
			default: return $urandom;
		endcase
	endfunction

	// Mostly positions and directions, the rest arbitrary w.
	function automatic logic [XW-1:0] pick_w();
		case ($urandom_range(4))
			0, 1: return Q_ONE;
			2: return '0;
			default: return pick_coord();
		endcase
	endfunction

	function automatic logic [XW-1:0] pick_coef(mat_kind_t kind);
		case (kind)
			MAT_SMALL: return $urandom_range(262144) - 32'd131072;
			MAT_EXTREME: begin
				case ($urandom_range(3))
					0: return SAT_MAX;
					1: return SAT_MIN;
					2: return LSB_ONE;
					default: return LSB_NEG;
				endcase
			end
			MAT_MIX: begin
				case ($urandom_range(5))
					0: return '0;
					1: return Q_ONE;
					2: return Q_NEG_ONE;
					3: return pick_coef(MAT_SMALL);
					4: return pick_coef(MAT_EXTREME);
					default: return $urandom;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic matrix_t make_matrix(mat_kind_t kind);
		matrix_t m;
		int      i;
		m = '0;
		if (kind == MAT_IDENTITY) begin
			m[REG_I_XY] = ONE_LO;
			m[REG_J_XY] = ONE_HI;
			m[REG_K_ZW] = ONE_LO;
			m[REG_T_ZW] = ONE_HI;
		end else begin
			for (i = 0; i < NUM_REGS; i++)
				m[i] = {pick_coef(kind), pick_coef(kind)};
		end
		return m;
	endfunction

	// Junk stays on the data ports while start is low.
	task automatic send_point(input logic [XW-1:0] px, input logic [XW-1:0] py,
			input logic [XW-1:0] pz, input logic [XW-1:0] pw);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			in_x <= $urandom;
			in_y <= $urandom;
			in_z <= $urandom;
			in_w <= $urandom;
			@(posedge clk);
		end
		start <= 1'b1;
		in_x <= px;
		in_y <= py;
		in_z <= pz;
		in_w <= pw;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Every load also hits one spare index, which must be dropped.
	task automatic load_matrix(input matrix_t m);
		int i;
		drain();
		write_reg(FIRST_SPARE_IDX + IDX_W'($urandom_range(7)), {$urandom, $urandom});
		for (i = 0; i < NUM_REGS; i++)
			write_reg(IDX_W'(i), m[i]);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		mat_kind_t kind;
		int        phase;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset matrix is the identity
		send_point('0, '0, '0, Q_ONE);
		send_point(SAT_MAX, SAT_MIN, LSB_NEG, '0);
		send_point(SAT_MIN, SAT_MAX, LSB_ONE, Q_ONE);
		send_point(LSB_NEG, LSB_NEG, LSB_NEG, LSB_NEG);
		send_point(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);

		// tiny coefficients: the shift must floor negative sums
		load_matrix({(2 * NUM_REGS){LSB_ONE}});
		send_point(LSB_NEG, '0, '0, '0);
		send_point(LSB_ONE, '0, '0, '0);
		send_point(LSB_NEG, LSB_NEG, LSB_NEG, LSB_NEG);
		send_point(FRAC_ALL, Q_NEG_ONE, '0, '0);

		load_matrix({(2 * NUM_REGS){SAT_MAX}});
		send_point(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
		send_point(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
		send_point(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN);

		load_matrix({(2 * NUM_REGS){SAT_MIN}});
		send_point(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
		send_point(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
		send_point('0, '0, '0, '0);

		// spare indexes leave the matrix untouched
		drain();
		write_reg(FIRST_SPARE_IDX, '1);
		write_reg(LAST_SPARE_IDX, '0);
		cfg_valid <= 1'b0;
		send_point(Q_ONE, Q_ONE, Q_ONE, Q_ONE);

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: kind = MAT_MIX;
				1: kind = MAT_SMALL;
				2: kind = MAT_FULL;
				3: kind = MAT_EXTREME;
				4: kind = MAT_MIX;
				default: kind = MAT_IDENTITY;
			endcase
			idle_pct = (phase < 2) ? 25 : (phase < 4) ? 86 : 0;
			load_matrix(make_matrix(kind));
			repeat (PHASE_POINTS) begin
				if ($urandom_range(149) == 0)
					drain();
				send_point(pick_coord(), pick_coord(), pick_coord(), pick_w());
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_homogeneous_point_transform OK");
		else
			$display("tb_homogeneous_point_transform NOT OK");
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("tb_homogeneous_point_transform NOT OK");
		$finish;
	end

endmodule
